// ----- rtl/stereo_feedback_delay_macros.svh -----
// assertion macros shared by the delay block
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

  // register field widths
  localparam int DELAY_BITS = 17;
  localparam int FB_BITS    = 16;
  localparam int MIX_BITS   = 17;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  // gain limits
  localparam logic [MIX_BITS-1:0] MIX_MAX    = MIX_BITS'(65536);
  localparam logic [MIX_BITS-1:0] MIX_BYPASS = MIX_BITS'(6);
  localparam logic [FB_BITS-1:0]  FB_MAX     = FB_BITS'(62259);

  // q.16 rounding
  localparam int Q_SHIFT    = 16;
  localparam int ROUND_HALF = 32768;

  // result queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE   = 8'd0,
    REG_DELAY    = 8'd1,
    REG_FEEDBACK = 8'd2,
    REG_MIX      = 8'd3
  } cfg_reg_t;

  // per-stage control shared by both lanes
  typedef struct packed {
    logic s0_read;
    logic s1_fwd;
    logic s1_zero;
    logic s2_write;
    logic s2_bypass;
  } lane_ctl_t;

endpackage

// ----- rtl/stereo_feedback_delay.sv -----
// channel  | dir | handshake               | word
// s_       | in  | s_tvalid / s_tready     | s_tdata: left_sample, right_sample
// m_       | out | m_tvalid / m_tready     | m_tdata: left_result, right_result
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one pair per cycle while s_tready is high; tap read, multiply and add/saturate stages lead to the queue
// a delay of one modulo the depth stops a pair from directly following the last: the tap is still in the multiply
// reset clears control and the write pointer; a wrap flag makes unwritten ram entries read zero
// a delay register write holds cfg_ready and s_tready low during the modulo reduction
// a four-word output queue parts the sides; s_tready drops while four words are in flight
`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay
  import sfd_pkg::*;
#(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // left_sample, right_sample
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // left_result, right_result
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(STORE_DEPTH - 1);

  // configuration registers
  logic                  enable;
  logic [DELAY_BITS-1:0] delay_raw;
  logic [FB_BITS-1:0]    fb_raw;
  logic [MIX_BITS-1:0]   mix_raw;
  logic [AW-1:0]         delay_mod;
  logic                  dmod_busy;
  logic                  cfg_wr;

  // effective gains and bypass
  logic [MIX_BITS-1:0]   mix_c;
  logic [FB_BITS-1:0]    fb_c;
  logic                  bypass;

  // stage 0: address generation
  logic [AW-1:0]         write_index;
  logic                  wrapped;
  logic [AW-1:0]         rd_addr;
  logic                  filled;
  logic                  hazard, fwd_hit;
  logic                  accept, pop;

  // pipe stages
  logic                  s1_valid, s1_bypass, s1_fwd, s1_zero;
  logic [AW-1:0]         s1_wr;
  logic                  s2_valid, s2_bypass;
  logic [AW-1:0]         s2_wr;
  logic [QCNT_BITS-1:0]  inflight, q_count, pipe_words;

  lane_ctl_t             ctl;
  logic signed [SB-1:0]  left_sample, right_sample, left_result, right_result;

  assign left_sample  = $signed(s_tdata[SB-1:0]);
  assign right_sample = $signed(s_tdata[2*SB-1:SB]);

  // ---------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------
  assign cfg_ready = ~dmod_busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      delay_raw <= DELAY_BITS'(1);
      fb_raw    <= '0;
      mix_raw   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   enable    <= cfg_data[0];
        REG_DELAY:    delay_raw <= cfg_data[DELAY_BITS-1:0];
        REG_FEEDBACK: fb_raw    <= cfg_data[FB_BITS-1:0];
        REG_MIX:      mix_raw   <= cfg_data[MIX_BITS-1:0];
        default:      ;  // unknown index, dropped
      endcase
    end
  end

  // delay reduced modulo the ring depth, off the item path
  sfd_dmod #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dmod (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr && (cfg_index == REG_DELAY)),
    .value  (cfg_data[DELAY_BITS-1:0]),
    .busy   (dmod_busy),
    .result (delay_mod)
  );

  assign mix_c  = (mix_raw > MIX_MAX) ? MIX_MAX : mix_raw;
  assign fb_c   = (fb_raw > FB_MAX) ? FB_MAX : fb_raw;
  assign bypass = ~enable | (mix_raw <= MIX_BYPASS) | (delay_raw == '0);

  // ---------------------------------------------------------------
  // stage 0: tap address, fill check, hazards
  // ---------------------------------------------------------------
  always_comb begin
    if (write_index >= delay_mod) begin
      rd_addr = write_index - delay_mod;
    end else begin
      rd_addr = AW'((AW+1)'(write_index) + DEPTH_W - (AW+1)'(delay_mod));
    end
  end

  // entries never written read as zero
  assign filled  = wrapped | (rd_addr < write_index);
  // tap still in the multiply stage: its stored value is not ready yet
  assign hazard  = ~bypass & s1_valid & ~s1_bypass & (s1_wr == rd_addr);
  // tap being written this cycle: catch it on the way into the ram
  assign fwd_hit = s2_valid & ~s2_bypass & (s2_wr == rd_addr);

  assign s_tready = ~dmod_busy & (inflight < QCNT_BITS'(QDEPTH)) & ~hazard;
  assign accept   = s_tvalid & s_tready;
  assign pop      = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      wrapped     <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      inflight    <= '0;
    end else begin
      if (accept && !bypass) begin
        if (write_index == LAST_IX) begin
          write_index <= '0;
          wrapped     <= 1'b1;
        end else begin
          write_index <= write_index + AW'(1);
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      unique case ({accept, pop})
        2'b10:   inflight <= inflight + QCNT_BITS'(1);
        2'b01:   inflight <= inflight - QCNT_BITS'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  // per-word pipe tags
  always_ff @(posedge clk) begin
    s1_bypass <= bypass;
    s1_fwd    <= fwd_hit & ~bypass;
    s1_zero   <= ~filled & ~bypass;
    s1_wr     <= write_index;
    s2_bypass <= s1_bypass;
    s2_wr     <= s1_wr;
  end

  assign ctl.s0_read   = accept;
  assign ctl.s1_fwd    = s1_fwd;
  assign ctl.s1_zero   = s1_zero;
  assign ctl.s2_write  = s2_valid & ~s2_bypass;
  assign ctl.s2_bypass = s2_bypass;

  // ---------------------------------------------------------------
  // lanes: one ring buffer and datapath per channel
  // ---------------------------------------------------------------
  sfd_lane #(
    .SAMPLE_BITS (SB),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_lane_left (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (s2_wr),
    .dry     (left_sample),
    .mix     (mix_c),
    .fb      (fb_c),
    .result  (left_result)
  );

  sfd_lane #(
    .SAMPLE_BITS (SB),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_lane_right (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (s2_wr),
    .dry     (right_sample),
    .mix     (mix_c),
    .fb      (fb_c),
    .result  (right_result)
  );

  // ---------------------------------------------------------------
  // merge both lanes into the output word queue
  // ---------------------------------------------------------------
  sfd_merge #(
    .SAMPLE_BITS (SB)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (s2_valid),
    .left     (left_result),
    .right    (right_result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .count    (q_count)
  );

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // words still in the two pipe stages
  assign pipe_words = QCNT_BITS'(s1_valid) + QCNT_BITS'(s2_valid);

  // credit count matches what the pipe and queue actually hold
  `SFD_ASSERT(a_inflight, inflight == pipe_words + q_count, "inflight out of step with pipe")
  // a forwarded tap was written by an earlier word, so it is never a fresh entry
  `SFD_ASSERT(a_fwd_filled, s1_valid && s1_fwd |-> !s1_zero, "forwarded tap marked unwritten")
  // every delayed word moves the write pointer
  `SFD_ASSERT(a_ptr_step, accept && !bypass |=> write_index != $past(write_index), "pointer stuck")
  // reset empties the pipe and the queue
  `SFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && inflight == '0, "words left after reset")

endmodule

// ----- rtl/sfd_ram.sv -----
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sfd_dmod.sv -----
module sfd_dmod
  import sfd_pkg::*;
#(
  parameter int STORE_DEPTH = 131072
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DELAY_BITS-1:0]          value,
  output logic                           busy,
  output logic [$clog2(STORE_DEPTH)-1:0] result
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int RECIP = (1 << DELAY_BITS) / STORE_DEPTH;
  localparam int RW    = (RECIP > 0) ? $clog2(RECIP + 1) : 1;
  localparam int CW    = (AW + 1 > DELAY_BITS + 1) ? AW + 1 : DELAY_BITS + 1;
  localparam int PW    = DELAY_BITS + RW;
  localparam int QW    = RW + CW;
  localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic                  v1, v2, v3;
  logic [DELAY_BITS-1:0] x1, x2, x3;
  logic [RW-1:0]         q2;
  logic [CW-1:0]         qd3;
  logic [PW-1:0]         prod;
  logic [QW-1:0]         qd_full;
  logic [CW-1:0]         rem, rem_fix;

  // quotient estimate is exact or one short, fixed by one subtract
  assign prod    = PW'(x1) * PW'(RECIP_W);
  assign qd_full = QW'(q2) * QW'(DEPTH_C);
  assign rem     = CW'(x3) - qd3;
  assign rem_fix = (rem >= DEPTH_C) ? rem - DEPTH_C : rem;
  assign busy    = v1 | v2 | v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      result <= AW'(1);
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        result <= rem_fix[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x1 <= value;
    end
    x2  <= x1;
    x3  <= x2;
    q2  <= prod[PW-1:DELAY_BITS];
    qd3 <= qd_full[CW-1:0];
  end

endmodule

// ----- rtl/sfd_lane.sv -----
module sfd_lane
  import sfd_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int STORE_DEPTH = 131072
) (
  input  logic                           clk,
  input  lane_ctl_t                      ctl,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic signed [SAMPLE_BITS-1:0]  dry,
  input  logic [MIX_BITS-1:0]            mix,
  input  logic [FB_BITS-1:0]             fb,
  output logic signed [SAMPLE_BITS-1:0]  result
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 18;
  localparam int SW = SB + 19;
  localparam logic signed [SB+2:0] SAT_HI = (SB+3)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+2:0] SAT_LO = -SAT_HI - (SB+3)'(1);

  function automatic logic [SB-1:0] sat(input logic signed [SB+2:0] v);
    logic [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic [SB-1:0]        ram_q;
  logic signed [SB-1:0] s1_dry, s2_dry, fwd_data, delayed;
  logic signed [PW-1:0] prod_mix, prod_fb, s2_prod_mix, s2_prod_fb;
  logic signed [SW-1:0] mix_sum, fb_sum;
  logic signed [SB+2:0] mix_q, fb_q;
  logic [SB-1:0]        store_val, wet_val;

  sfd_ram #(
    .WIDTH (SB),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.s2_write),
    .waddr (wr_addr),
    .wdata (store_val),
    .re    (ctl.s0_read),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // stage 1: pick the tap and multiply by both gains
  always_comb begin
    if (ctl.s1_zero) begin
      delayed = '0;
    end else if (ctl.s1_fwd) begin
      delayed = fwd_data;
    end else begin
      delayed = $signed(ram_q);
    end
  end

  assign prod_mix = delayed * $signed({1'b0, mix});
  assign prod_fb  = delayed * $signed({2'b0, fb});

  // stage 2: dry + round(product), saturated
  assign mix_sum   = (SW'(s2_dry) <<< Q_SHIFT) + SW'(s2_prod_mix) + SW'(ROUND_HALF);
  assign fb_sum    = (SW'(s2_dry) <<< Q_SHIFT) + SW'(s2_prod_fb) + SW'(ROUND_HALF);
  assign mix_q     = mix_sum[SW-1:Q_SHIFT];
  assign fb_q      = fb_sum[SW-1:Q_SHIFT];
  assign wet_val   = sat(mix_q);
  assign store_val = sat(fb_q);
  assign result    = ctl.s2_bypass ? s2_dry : $signed(wet_val);

  always_ff @(posedge clk) begin
    s1_dry      <= dry;
    s2_dry      <= s1_dry;
    s2_prod_mix <= prod_mix;
    s2_prod_fb  <= prod_fb;
    fwd_data    <= $signed(store_val);
  end

endmodule

// ----- rtl/sfd_merge.sv -----
module sfd_merge
  import sfd_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic signed [SAMPLE_BITS-1:0]          left,
  input  logic signed [SAMPLE_BITS-1:0]          right,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
  output logic [QCNT_BITS-1:0]                   count
);

  localparam int EW = 2 * SAMPLE_BITS;
  localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  logic [EW-1:0]        q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic                 pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = DW'(q[rptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  // both lanes land in one word, left in the low half
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= {right, left};
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

// stereo feedback delay bench: directed corner words, then random config phases
// a behavioral echo model predicts every output word, checked in order
module testbench;
  import sfd_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int WORD_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int RING_DEPTH  = 131072;
  localparam int PAIR_TARGET = 750;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [16:0] DELAY_LONGEST = 17'h1FFFF;
  localparam logic [15:0] FB_ALL_ONES   = 16'hFFFF;
  localparam logic [16:0] MIX_ALL_ONES  = 17'h1FFFF;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t right;
    sample_t left;
  } stereo_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // slave side
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WORD_BITS-1:0] s_tdata  = '0;   // left_sample, right_sample
  // master side
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_BITS-1:0] m_tdata;         // left_result, right_result
  // configuration writes
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  stereo_feedback_delay dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // echo model: register mirror, both rings and the shared write pointer
  // ---------------------------------------------------------------------------
  logic        dly_enable = 1'b0;
  logic [16:0] dly_len    = 17'd1;
  logic [15:0] fb_gain    = '0;
  logic [16:0] mix_amt    = '0;

  bit signed [SAMPLE_BITS-1:0] left_ring  [RING_DEPTH];   // zero at start, like reset
  bit signed [SAMPLE_BITS-1:0] right_ring [RING_DEPTH];
  logic [16:0]                 ring_wr = '0;

  stereo_t results_due[$];        // predicted output words, oldest first
  logic [WORD_BITS-1:0] pairs_to_send[$];

  int unsigned pairs_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  // sender and receiver behavior, changed between phases
  bit steady_source = 1'b1;
  int sink_mode     = 0;

  function automatic sample_t clamp_sample(longint v);
    if (v > longint'(FULL_POS)) return FULL_POS;
    if (v < longint'(FULL_NEG)) return FULL_NEG;
    return sample_t'(v);
  endfunction

  // sample times q.16 gain, round half up (arithmetic shift is a floor)
  function automatic longint scale_q16(longint x, longint g);
    return (x * g + longint'(ROUND_HALF)) >>> Q_SHIFT;
  endfunction

  function automatic stereo_t echo_step(sample_t dry_l, sample_t dry_r);
    stereo_t     res;
    longint      mix;
    longint      fb;
    longint      tap_l;
    longint      tap_r;
    logic [16:0] rd;
    mix = (mix_amt > MIX_MAX) ? longint'(MIX_MAX) : longint'(mix_amt);
    fb  = (fb_gain > FB_MAX) ? longint'(FB_MAX) : longint'(fb_gain);
    // bypass leaves the rings and pointer alone
    if (!dly_enable || mix <= longint'(MIX_BYPASS) || dly_len == '0) begin
      res.left  = dry_l;
      res.right = dry_r;
      return res;
    end
    rd    = ring_wr - dly_len;   // 17-bit wrap is the ring modulo
    tap_l = longint'(left_ring[rd]);
    tap_r = longint'(right_ring[rd]);
    res.left  = clamp_sample(longint'(dry_l) + scale_q16(tap_l, mix));
    res.right = clamp_sample(longint'(dry_r) + scale_q16(tap_r, mix));
    left_ring[ring_wr]  = clamp_sample(longint'(dry_l) + scale_q16(tap_l, fb));
    right_ring[ring_wr] = clamp_sample(longint'(dry_r) + scale_q16(tap_r, fb));
    ring_wr = ring_wr + 17'd1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of words with random gaps, or steady when asked
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready)
        results_due.push_back(echo_step(s_tdata[SAMPLE_BITS-1:0],
                                        s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pairs_to_send.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pairs_to_send.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = steady_source ? 0 : $urandom_range(0, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern per sink_mode, checks each word against the model
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    stereo_t got;
    stereo_t want;
    logic    ready_next;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.left  = m_tdata[SAMPLE_BITS-1:0];
        got.right = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word left=%0d right=%0d", got.left, got.right);
        end else begin
          want = results_due.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                       want.left, want.right, got.left, got.right);
          end
        end
      end
      case (sink_mode)
        0: ready_next = 1'b1;
        1: begin
          // random stall runs
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
          end
        end
        default: ready_next = (cycle_count % 5) < 2;   // periodic, mostly stalled
      endcase
      m_tready <= ready_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle means no word pending and none in the pipe, followed by a settling wait
  task automatic wait_quiet();
    while (pairs_to_send.size() > 0 || s_tvalid || results_due.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one register write; the mirror follows the accepted value
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:   dly_enable = val[0];
      REG_DELAY:    dly_len    = val[DELAY_BITS-1:0];
      REG_FEEDBACK: fb_gain    = val[FB_BITS-1:0];
      REG_MIX:      mix_amt    = val[MIX_BITS-1:0];
      default: ;    // unused index, dropped
    endcase
    cfg_valid <= 1'b0;
  endtask

  // field value, sometimes with junk above the field width
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(logic [CFG_DATA_BITS-1:0] val,
                                                         int width);
    logic [CFG_DATA_BITS-1:0] field_mask;
    field_mask = (CFG_DATA_BITS'(1) << width) - 1;
    if ($urandom_range(0, 3) == 0)
      return (CFG_DATA_BITS'($urandom()) & ~field_mask) | val;
    return val;
  endfunction

  task automatic send_pair(sample_t l, sample_t r);
    pairs_to_send.push_back({r, l});
    pairs_queued++;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return sample_t'($signed($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          n_items;
    logic [16:0] dly_pick;
    logic [15:0] fb_pick;
    logic [16:0] mix_pick;
    bit          first_phase;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state is bypass: extremes pass straight through
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair('0, -1);
    send_pair(1, sample_t'(24'h555555));
    wait_quiet();

    // shortest delay, top feedback and full mix: rings saturate
    write_reg(REG_ENABLE, 1);
    write_reg(REG_DELAY, 1);
    write_reg(REG_FEEDBACK, CFG_DATA_BITS'(FB_MAX));
    write_reg(REG_MIX, CFG_DATA_BITS'(MIX_MAX));
    repeat (4) send_pair(FULL_POS, FULL_NEG);
    repeat (2) send_pair(FULL_NEG, FULL_POS);
    repeat (2) send_pair('0, '0);
    wait_quiet();

    // feedback and mix above their caps get clamped
    write_reg(REG_DELAY, 3);
    write_reg(REG_FEEDBACK, CFG_DATA_BITS'(FB_ALL_ONES));
    write_reg(REG_MIX, CFG_DATA_BITS'(MIX_ALL_ONES));
    send_pair(FULL_POS, FULL_POS);
    send_pair(FULL_NEG, FULL_NEG);
    send_pair(12345, -54321);
    send_pair(FULL_POS, FULL_NEG);
    wait_quiet();

    // mix at the bypass threshold
    write_reg(REG_MIX, CFG_DATA_BITS'(MIX_BYPASS));
    send_pair(FULL_POS, -7);
    send_pair(99, FULL_NEG);
    wait_quiet();

    // one step past the threshold, but zero delay still bypasses
    write_reg(REG_MIX, CFG_DATA_BITS'(MIX_BYPASS) + 1);
    write_reg(REG_DELAY, 0);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(-1, 1);
    wait_quiet();

    // longest delay reads entries never written
    write_reg(REG_DELAY, CFG_DATA_BITS'(DELAY_LONGEST));
    send_pair(FULL_NEG, FULL_POS);
    send_pair(777, -777);
    wait_quiet();

    // write to an index past the register map is dropped
    write_reg(REG_MIX + 1, CFG_DATA_BITS'($urandom()));
    send_pair(4242, -4242);
    wait_quiet();

    // random phases: new settings each time, mostly short delays so feedback builds
    first_phase = 1'b1;
    while (pairs_queued < PAIR_TARGET + 23) begin
      if (first_phase || $urandom_range(0, 9) < 6)
        write_reg(REG_ENABLE, with_junk($urandom_range(0, 7) != 0, 1));
      if (first_phase || $urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 11))
          0: dly_pick = 17'd1;
          1: dly_pick = 17'd2;
          2: dly_pick = '0;
          3: dly_pick = DELAY_LONGEST;
          4: dly_pick = 17'($urandom_range(1, RING_DEPTH - 1));
          default: dly_pick = 17'($urandom_range(1, 40));
        endcase
        write_reg(REG_DELAY, with_junk(CFG_DATA_BITS'(dly_pick), DELAY_BITS));
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 5))
          0: fb_pick = '0;
          1: fb_pick = FB_MAX;
          2: fb_pick = FB_ALL_ONES;
          3: fb_pick = 16'($urandom());
          default: fb_pick = 16'($urandom_range(0, FB_MAX));
        endcase
        write_reg(REG_FEEDBACK, with_junk(CFG_DATA_BITS'(fb_pick), FB_BITS));
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: mix_pick = '0;
          1: mix_pick = MIX_BYPASS;
          2: mix_pick = MIX_BYPASS + 1;
          3: mix_pick = MIX_MAX;
          4: mix_pick = MIX_ALL_ONES;
          5: mix_pick = 17'($urandom());
          default: mix_pick = 17'($urandom_range(0, MIX_MAX));
        endcase
        write_reg(REG_MIX, with_junk(CFG_DATA_BITS'(mix_pick), MIX_BITS));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(8'($urandom_range(REG_MIX + 1, 255)), CFG_DATA_BITS'($urandom()));
      first_phase = 1'b0;

      steady_source = ($urandom_range(0, 3) == 0);
      sink_mode     = $urandom_range(0, 2);
      n_items       = $urandom_range(10, 50);
      repeat (n_items) send_pair(pick_sample(), pick_sample());
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
